// ===== design/sxd_pkg.sv =====
// Shared types and codes for the sprite XOR draw framebuffer.
`timescale 1ns / 1ps

package sxd_pkg;

  // Command codes carried in the op field of a command word.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DRAW  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // One command word.
  typedef struct packed {
    op_t        op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] sprite_byte;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic collision;
    logic pixel;
    logic row_drawn;
  } rsp_t;

endpackage

// ===== design/sprite_xor_draw_framebuffer_unit.sv =====
// Top level of the monochrome framebuffer with XOR sprite row drawing.
`timescale 1ns / 1ps

// A result word is registered in the update state that follows acceptance and is
// shown with done high for exactly one cycle; the receiver cannot stall it.
// No new command word is taken during the update, because the line RAM is
// read in the cycle a word is accepted and written back in the cycle after.
// Reset is synchronous and active high: it blanks the screen at once by clearing
// the per-line valid bits, clears the collision flag and leaves the block idle.

module sprite_xor_draw_framebuffer_unit
  import sxd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int LW = $clog2(SCREEN_HEIGHT);

  localparam logic [8:0] W1 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] W2 = 9'(2 * SCREEN_WIDTH);
  localparam logic [8:0] H1 = 9'(SCREEN_HEIGHT);
  localparam logic [8:0] H2 = 9'(2 * SCREEN_HEIGHT);
  localparam logic [8:0] H4 = 9'(4 * SCREEN_HEIGHT);
  localparam logic [6:0] H_LIMIT = 7'(SCREEN_HEIGHT);

  state_t state;
  state_t state_next;

  // Command fields held for the update cycle.
  op_t           op_q;
  logic [CW-1:0] col_q;
  logic [LW-1:0] line_q;
  logic [7:0]    sprite_q;
  logic          on_screen_q;

  // Screen state: one valid bit per line stands in for the clear, so a line
  // that has not been written since reset or the last clear reads as blank.
  logic [SCREEN_HEIGHT-1:0] valid;
  logic                     flag;
  logic                     flag_next;

  logic [8:0]    x_a, x_b;
  logic [8:0]    y_a, y_b, y_c;
  logic [6:0]    draw_sum;
  logic          on_screen_in;
  logic [CW-1:0] col_in;
  logic [LW-1:0] addr_in;
  logic          load;

  logic                    ram_we;
  logic [SCREEN_WIDTH-1:0] rd_data;
  logic [SCREEN_WIDTH-1:0] new_word;
  logic                    hit;
  logic                    alu_pixel;
  rsp_t                    rsp_next;

  // The positions are at most eight bits wide and the screen is at least 64
  // columns and 32 lines, so a few conditional subtractions give the remainder.
  always_comb begin
    x_a          = (9'(cmd.x_pos) >= W2) ? 9'(cmd.x_pos) - W2 : 9'(cmd.x_pos);
    x_b          = (x_a >= W1) ? x_a - W1 : x_a;
    y_a          = (9'(cmd.y_pos) >= H4) ? 9'(cmd.y_pos) - H4 : 9'(cmd.y_pos);
    y_b          = (y_a >= H2) ? y_a - H2 : y_a;
    y_c          = (y_b >= H1) ? y_b - H1 : y_b;
    col_in       = x_b[CW-1:0];
    draw_sum     = 7'(y_c) + 7'(cmd.row_index);
    on_screen_in = (draw_sum < H_LIMIT);
    addr_in      = (cmd.op == OP_DRAW) ? draw_sum[LW-1:0] : y_c[LW-1:0];
  end

  // The line RAM is read at the address of the incoming word, so its data is
  // ready in the update cycle that follows acceptance.
  sxd_ram #(
    .WIDTH(SCREEN_WIDTH),
    .DEPTH(SCREEN_HEIGHT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(line_q),
    .wdata(new_word),
    .raddr(addr_in),
    .rdata(rd_data)
  );

  sxd_line_alu #(
    .WIDTH(SCREEN_WIDTH)
  ) u_alu (
    .line_word (rd_data),
    .line_valid(valid[line_q]),
    .col       (col_q),
    .sprite    (sprite_q),
    .new_word  (new_word),
    .hit       (hit),
    .pixel     (alu_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: accept in idle, then a single update state that writes the line
  // back on an on-screen draw, moves the screen state and forms the result word.
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    load       = 1'b0;
    ram_we     = 1'b0;
    flag_next  = flag;
    rsp_next   = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          load       = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        busy       = 1'b1;
        state_next = ST_IDLE;
        case (op_q)
          OP_BEGIN: begin
            flag_next = 1'b0;
          end
          OP_DRAW: begin
            if (on_screen_q) begin
              ram_we             = 1'b1;
              flag_next          = flag | hit;
              rsp_next.row_drawn = 1'b1;
            end
          end
          OP_READ: begin
            rsp_next.pixel = alu_pixel;
          end
          default: begin
          end
        endcase
        rsp_next.collision = flag_next;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_q        <= cmd.op;
      col_q       <= col_in;
      line_q      <= addr_in;
      sprite_q    <= cmd.sprite_byte;
      on_screen_q <= on_screen_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      flag  <= 1'b0;
      done  <= 1'b0;
    end else begin
      flag <= flag_next;
      done <= (state == ST_UPDATE);
      if (state == ST_UPDATE) begin
        case (op_q)
          OP_CLEAR: begin
            valid <= '0;
          end
          OP_DRAW: begin
            if (on_screen_q) begin
              valid[line_q] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      result <= rsp_next;
    end
  end

  // A result word only ever follows an update cycle.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without a preceding update cycle");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start an update");

  // The line RAM is only written by an on-screen row draw.
  a_write_only_draw: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_UPDATE && op_q == OP_DRAW && on_screen_q))
    else $error("line RAM written outside an on-screen draw");

  // The reported collision bit is the flag as it stands after the command.
  a_collision_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.collision == flag))
    else $error("collision bit disagrees with the collision flag");

  // After a clear the whole screen reads blank.
  a_clear_blanks: assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_CLEAR) |-> (valid == '0))
    else $error("screen not blank after clear");

endmodule

// ===== design/sxd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sxd_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sxd_line_alu.sv =====
// Shared line unit: places a sprite row on a screen line, XORs it in and picks pixels.
`timescale 1ns / 1ps

module sxd_line_alu #(
  parameter int WIDTH = 128
) (
  input  logic [WIDTH-1:0]         line_word,
  input  logic                     line_valid,
  input  logic [$clog2(WIDTH)-1:0] col,
  input  logic [7:0]               sprite,
  output logic [WIDTH-1:0]         new_word,
  output logic                     hit,
  output logic                     pixel
);

  logic [7:0]       rev;
  logic [WIDTH+7:0] wide;
  logic [WIDTH-1:0] old_word;
  logic [WIDTH-1:0] mask;

  // Bit c of a line word is the pixel in column c, so the leftmost sprite bit
  // must land on the lowest column; bits shifted past the right edge fall off.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[j] = sprite[7-j];
    end
    wide     = (WIDTH+8)'(rev) << col;
    mask     = wide[WIDTH-1:0];
    old_word = line_valid ? line_word : '0;
    new_word = old_word ^ mask;
    hit      = |(old_word & mask);
    pixel    = old_word[col];
  end

endmodule
